@@ rtl/core/qph_pkg.sv @@
// Shared widths, codes and control types for the quadratic-probe hash table.
`timescale 1ns / 1ps
`default_nettype none
package qph_pkg;
	localparam int ACTION_W = 2;
	localparam int KEY_W    = 31;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 11;
	localparam int SLOT_W   = 2;
	localparam int META_W   = SLOT_W + KEY_W;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 48;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_NEVER = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_LIVE  = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_TOMB  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd5;

	typedef struct packed {
		logic start;
		logic step;
	} qph_probe_cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/quadratic_probe_hash_table.sv @@
// Quadratic-probe hash table: one request in, one result out; probes run on a shared adder.
// Each probe is a memory read (S_READ), then a compare (S_EVAL); the chain ends in S_DONE,
//   which registers the result once the output is free.
// Throughput: one request at a time; the next beat is taken once the result is registered.
// Reset: after arst_n the slot-state memory is swept to never-used, one slot per cycle,
//   and s_tready stays low until the sweep is done; the live count resets to zero.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_probe_hash_table import qph_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // action[1:0], key[32:2], value[64:33]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata   // status[2:0], value_out[34:3], entry_count[45:35]
);
	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = IW + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [IW-1:0]       clr_q;
	logic [CW-1:0]       live_q;
	logic [ACTION_W-1:0] act_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  val_q;
	logic                found_q;
	logic                have_vac_q;
	logic [IW-1:0]       hit_q;
	logic [IW-1:0]       vac_q;
	logic [VALUE_W-1:0]  hit_pay_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	qph_probe_cmd_t      pcmd;
	logic [IW-1:0]       slot;
	logic                last;
	logic [SLOT_W-1:0]   rd_state;
	logic [KEY_W-1:0]    rd_key;
	logic [VALUE_W-1:0]  rd_payload;

	logic                meta_we;
	logic                pay_we;
	logic [IW-1:0]       wr_addr;
	logic [META_W-1:0]   wr_meta;
	logic                accept;
	logic                out_free;
	logic                is_live;
	logic                is_match;
	logic                stop;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  vout;
	logic [CW-1:0]       live_nxt;
	logic [CW+COUNT_W-1:0] cnt_wide;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign is_live  = rd_state == SLOT_LIVE;
	assign is_match = is_live && (rd_key == key_q);
	assign stop     = (rd_state == SLOT_NEVER) || last;

	assign pcmd.start = accept;
	assign pcmd.step  = (state_q == S_EVAL) && !is_match && !stop;

	qph_prober #(.IW(IW)) u_prober (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pcmd),
		.home   (s_tdata[IW+1:2]),
		.slot   (slot),
		.last   (last)
	);

	qph_slots #(.IW(IW)) u_slots (
		.clk        (clk),
		.rd_en      (state_q == S_READ),
		.rd_addr    (slot),
		.meta_we    (meta_we),
		.pay_we     (pay_we),
		.wr_addr    (wr_addr),
		.wr_meta    (wr_meta),
		.wr_payload (val_q),
		.rd_state   (rd_state),
		.rd_key     (rd_key),
		.rd_payload (rd_payload)
	);

	// Resolve the request once the probe chain has ended; during the reset sweep, write never-used slots
	always_comb begin
		meta_we  = 1'b0;
		pay_we   = 1'b0;
		wr_addr  = found_q ? hit_q : vac_q;
		wr_meta  = {SLOT_LIVE, key_q};
		status   = STAT_ABSENT;
		vout     = '0;
		live_nxt = live_q;
		if (state_q == S_CLEAR) begin
			meta_we = 1'b1;
			wr_addr = clr_q;
			wr_meta = {SLOT_NEVER, key_q};
		end else if (state_q == S_DONE) begin
			unique case (act_q)
				ACT_INSERT: begin
					if (found_q) begin
						pay_we = out_free;
						status = STAT_UPDATED;
					end else if (have_vac_q) begin
						meta_we  = out_free;
						pay_we   = out_free;
						live_nxt = live_q + CW'(1);
						status   = STAT_INSERTED;
					end else begin
						status = STAT_FULL;
					end
				end
				ACT_REMOVE: begin
					if (found_q) begin
						meta_we  = out_free;
						wr_meta  = {SLOT_TOMB, key_q};
						live_nxt = live_q - CW'(1);
						status   = STAT_REMOVED;
					end
				end
				default: begin
					// lookup; the unused action code behaves the same
					if (found_q) begin
						vout   = hit_pay_q;
						status = STAT_FOUND;
					end
				end
			endcase
		end
	end

	assign cnt_wide = {{COUNT_W{1'b0}}, live_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			live_q     <= '0;
			found_q    <= 1'b0;
			have_vac_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result may replace one taken in the same cycle
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						found_q    <= 1'b0;
						have_vac_q <= 1'b0;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (is_match) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						if (!is_live && !have_vac_q) begin
							have_vac_q <= 1'b1;
						end
						state_q <= stop ? S_DONE : S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						live_q  <= live_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, probe payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_tdata[1:0];
			key_q <= s_tdata[32:2];
			val_q <= s_tdata[64:33];
		end
		if (state_q == S_EVAL) begin
			if (is_match) begin
				hit_q     <= slot;
				hit_pay_q <= rd_payload;
			end else if (!is_live && !have_vac_q) begin
				vac_q <= slot;
			end
		end
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {2'b00, cnt_wide[COUNT_W-1:0], vout, status};
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule
`default_nettype wire

@@ rtl/core/qph_prober.sv @@
// Probe address generator: one shared adder walks home, home+1, home+4, ...
`timescale 1ns / 1ps
`default_nettype none
module qph_prober import qph_pkg::*; #(
	parameter int IW = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire qph_probe_cmd_t cmd,
	input  wire logic [IW-1:0]  home,
	output logic      [IW-1:0]  slot,
	output logic                last
);
	logic [IW-1:0] slot_q;
	logic [IW-1:0] inc_q;
	logic [IW-1:0] cnt_q;

	// (home + i*i) advanced by the odd increment 2i+1, modulo the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			inc_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			slot_q <= home;
			inc_q  <= IW'(1);
			cnt_q  <= '0;
		end else if (cmd.step) begin
			slot_q <= slot_q + inc_q;
			inc_q  <= inc_q + IW'(2);
			cnt_q  <= cnt_q + IW'(1);
		end
	end

	assign slot = slot_q;
	assign last = &cnt_q;
endmodule
`default_nettype wire

@@ rtl/core/qph_slots.sv @@
// Slot storage: state+key memory and payload memory, one write and one read port each.
`timescale 1ns / 1ps
`default_nettype none
module qph_slots import qph_pkg::*; #(
	parameter int IW = 10
) (
	input  wire logic               clk,
	input  wire logic               rd_en,
	input  wire logic [IW-1:0]      rd_addr,
	input  wire logic               meta_we,
	input  wire logic               pay_we,
	input  wire logic [IW-1:0]      wr_addr,
	input  wire logic [META_W-1:0]  wr_meta,
	input  wire logic [VALUE_W-1:0] wr_payload,
	output logic      [SLOT_W-1:0]  rd_state,
	output logic      [KEY_W-1:0]   rd_key,
	output logic      [VALUE_W-1:0] rd_payload
);
	localparam int DEPTH = 1 << IW;

	logic [META_W-1:0]  meta_mem [DEPTH];
	logic [VALUE_W-1:0] pay_mem  [DEPTH];
	logic [META_W-1:0]  meta_q;
	logic [VALUE_W-1:0] pay_q;

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_addr] <= wr_meta;
		end
		if (rd_en) begin
			meta_q <= meta_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[wr_addr] <= wr_payload;
		end
		if (rd_en) begin
			pay_q <= pay_mem[rd_addr];
		end
	end

	assign rd_state   = meta_q[META_W-1:KEY_W];
	assign rd_key     = meta_q[KEY_W-1:0];
	assign rd_payload = pay_q;
endmodule
`default_nettype wire

@@ sim/tb_quadratic_probe_hash_table.sv @@
// Self-checking testbench for the quadratic-probe hash table: directed and random requests.
`timescale 1ns / 1ps
module tb_quadratic_probe_hash_table;
	import qph_pkg::*;

	localparam int TABLE_SIZE  = 1024;
	localparam int IDX_W       = 10;
	localparam int HI_W        = KEY_W - IDX_W;
	localparam int STALL_LIMIT = 20000;
	localparam int KEY_POOL_N  = 192;
	localparam int HOME_SET_N  = 96;
	localparam int CHAIN_N     = 190;
	localparam int MAX_REPORTS = 10;

	// unused action code; the block treats it as a look up
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [KEY_W-1:0]    key;
		logic [ACTION_W-1:0] action;
	} request_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  entry_count;
		logic [VALUE_W-1:0]  value_out;
		logic [STATUS_W-1:0] status;
	} response_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;  // action[1:0], key[32:2], value[64:33]
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // status[2:0], value_out[34:3], entry_count[45:35]

	quadratic_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// shadow copy of the table
	logic [SLOT_W-1:0]  shadow_state   [TABLE_SIZE];
	logic [KEY_W-1:0]   shadow_key     [TABLE_SIZE];
	logic [VALUE_W-1:0] shadow_payload [TABLE_SIZE];
	int                 shadow_live;

	request_t  requests_to_send[$];
	response_t responses_due[$];
	response_t got_rsp;

	logic [KEY_W-1:0] key_pool [KEY_POOL_N];
	int  send_gap_pct = 0;
	int  take_gap_pct = 0;
	bit  input_beat   = 1'b0;
	int  error_count  = 0;
	int  quiet_cycles = 0;

	function automatic response_t table_apply(request_t req);
		logic [IDX_W-1:0] home, slot, hit_slot, free_slot;
		logic             hit, have_free, done;
		int               i;
		response_t        rsp;
		home      = req.key[IDX_W-1:0];
		hit       = 1'b0;
		have_free = 1'b0;
		done      = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (i = 0; i < TABLE_SIZE && !done; i++) begin
			slot = home + IDX_W'(i * i);
			if (shadow_state[slot] == SLOT_LIVE) begin
				if (shadow_key[slot] == req.key) begin
					hit      = 1'b1;
					hit_slot = slot;
					done     = 1'b1;
				end
			end else begin
				if (!have_free) begin
					have_free = 1'b1;
					free_slot = slot;
				end
				if (shadow_state[slot] == SLOT_NEVER)
					done = 1'b1;
			end
		end
		rsp.value_out = '0;
		case (req.action)
			ACT_INSERT: begin
				if (hit) begin
					shadow_payload[hit_slot] = req.value;
					rsp.status = STAT_UPDATED;
				end else if (have_free) begin
					shadow_state[free_slot]   = SLOT_LIVE;
					shadow_key[free_slot]     = req.key;
					shadow_payload[free_slot] = req.value;
					shadow_live++;
					rsp.status = STAT_INSERTED;
				end else begin
					rsp.status = STAT_FULL;
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					shadow_state[hit_slot] = SLOT_TOMB;
					if (shadow_live > 0)
						shadow_live--;
					rsp.status = STAT_REMOVED;
				end else begin
					rsp.status = STAT_ABSENT;
				end
			end
			default: begin
				if (hit) begin
					rsp.value_out = shadow_payload[hit_slot];
					rsp.status    = STAT_FOUND;
				end else begin
					rsp.status = STAT_ABSENT;
				end
			end
		endcase
		rsp.entry_count = COUNT_W'(shadow_live);
		return rsp;
	endfunction

	task automatic push_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
			logic [VALUE_W-1:0] value);
		request_t req;
		req.action = act;
		req.key    = key;
		req.value  = value;
		requests_to_send.push_back(req);
	endtask

	task automatic push_random();
		int                  roll;
		logic [ACTION_W-1:0] act;
		logic [KEY_W-1:0]    key;
		roll = $urandom_range(99);
		if (roll < 40)
			act = ACT_INSERT;
		else if (roll < 62)
			act = ACT_REMOVE;
		else if (roll < 90)
			act = ACT_LOOKUP;
		else
			act = ACT_SPARE;
		// mostly a recurring key set so removes and lookups hit
		if ($urandom_range(99) < 80)
			key = key_pool[$urandom_range(KEY_POOL_N - 1)];
		else
			key = KEY_W'($urandom());
		push_request(act, key, $urandom());
	endtask

	task automatic drain_requests();
		while (requests_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	task automatic report_error(string note, response_t want, response_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s: expected status %0d value_out %h count %0d, got status %0d value_out %h count %0d",
				$time, note, want.status, want.value_out, want.entry_count,
				got.status, got.value_out, got.entry_count);
	endtask

	initial
		forever #1 clk = ~clk;

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || input_beat) begin
				if (requests_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					s_tdata  <= IN_W'(requests_to_send.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	// monitor: predict on each input beat, check each output beat
	always @(posedge clk) begin
		input_beat = arst_n && s_tvalid && s_tready;
		if (input_beat)
			responses_due.push_back(table_apply(request_t'(s_tdata[$bits(request_t)-1:0])));
		if (arst_n && m_tvalid && m_tready) begin
			got_rsp = response_t'(m_tdata[$bits(response_t)-1:0]);
			if (responses_due.size() == 0)
				report_error("result beat with nothing outstanding", '0, got_rsp);
			else if (got_rsp != responses_due[0])
				report_error("result mismatch", responses_due.pop_front(), got_rsp);
			else
				void'(responses_due.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("quadratic_probe_hash_table regression: fail");
			$finish;
		end
	end

	initial begin
		int               n;
		logic [IDX_W-1:0] home_set [HOME_SET_N];
		logic [IDX_W-1:0] chain_home;
		logic [KEY_W-1:0] chain_keys [CHAIN_N];
		for (n = 0; n < TABLE_SIZE; n++) begin
			shadow_state[n]   = SLOT_NEVER;
			shadow_key[n]     = '0;
			shadow_payload[n] = '0;
		end
		shadow_live = 0;
		// shared homes give short collision chains
		for (n = 0; n < HOME_SET_N; n++)
			home_set[n] = IDX_W'($urandom());
		for (n = 0; n < KEY_POOL_N; n++)
			key_pool[n] = {HI_W'($urandom()), home_set[$urandom_range(HOME_SET_N - 1)]};

		send_gap_pct = 33;
		take_gap_pct = 70;

		// directed: empty table, key extremes, collisions on home 0, tombstones
		push_request(ACT_LOOKUP, 31'd0, 32'h0);
		push_request(ACT_REMOVE, 31'd0, 32'hFFFF_FFFF);
		push_request(ACT_INSERT, 31'd0, 32'h0);
		push_request(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_request(ACT_LOOKUP, 31'h7FFF_FFFF, 32'h0);
		push_request(ACT_INSERT, 31'd0, 32'hFFFF_FFFF);
		push_request(ACT_SPARE, 31'd0, 32'h1234_5678);
		push_request(ACT_INSERT, 31'd1024, 32'hA5A5_A5A5);
		push_request(ACT_INSERT, 31'd2048, 32'h5A5A_5A5A);
		push_request(ACT_REMOVE, 31'd1024, 32'h0);
		push_request(ACT_LOOKUP, 31'd2048, 32'h0);
		push_request(ACT_LOOKUP, 31'd1024, 32'h0);
		push_request(ACT_INSERT, 31'd3072, 32'h0F0F_0F0F);
		push_request(ACT_REMOVE, 31'd1024, 32'h0);
		push_request(ACT_SPARE, 31'd3072, 32'h0);
		push_request(ACT_INSERT, 31'h7FFF_FC00, 32'hF0F0_F0F0);
		push_request(ACT_REMOVE, 31'd0, 32'h0);
		push_request(ACT_LOOKUP, 31'd0, 32'h0);
		push_request(ACT_LOOKUP, 31'h7FFF_FC00, 32'h0);
		push_request(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0);
		push_request(ACT_LOOKUP, 31'h7FFF_FFFF, 32'h0);

		repeat (7) @(posedge clk);
		#0.5 arst_n = 1'b1;

		for (n = 0; n < 600; n++)
			push_random();
		drain_requests();

		send_gap_pct = 70;
		take_gap_pct = 33;
		for (n = 0; n < 600; n++)
			push_random();
		drain_requests();

		send_gap_pct = 0;
		take_gap_pct = 0;
		// pile keys onto one home until the probe sequence runs out of room
		chain_home = IDX_W'($urandom());
		for (n = 0; n < CHAIN_N; n++) begin
			chain_keys[n] = {HI_W'($urandom()), chain_home};
			push_request(ACT_INSERT, chain_keys[n], $urandom());
		end
		for (n = 0; n < 12; n++)
			push_request(ACT_REMOVE, chain_keys[$urandom_range(CHAIN_N - 1)], $urandom());
		for (n = 0; n < 12; n++)
			push_request(ACT_INSERT, {HI_W'($urandom()), chain_home}, $urandom());
		for (n = 0; n < 24; n++)
			push_request(ACT_LOOKUP, chain_keys[$urandom_range(CHAIN_N - 1)], $urandom());
		for (n = 0; n < 380; n++)
			push_random();
		drain_requests();

		while (responses_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("quadratic_probe_hash_table regression: pass");
		else
			$display("quadratic_probe_hash_table regression: fail");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/qph_pkg.sv
rtl/core/qph_prober.sv
rtl/core/qph_slots.sv
rtl/core/quadratic_probe_hash_table.sv
sim/tb_quadratic_probe_hash_table.sv
